### rtl/pcs_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the prime counting sieve.
// No dependencies; imported by prime_count_sieve.
package pcs_pkg;

	localparam int MAX_LIMIT = 4095;
	localparam int LIMIT_W   = $clog2(MAX_LIMIT + 1);
	localparam int COUNT_W   = 10;
	localparam int MAP_DEPTH = MAX_LIMIT + 1;
	localparam int IDX_W     = LIMIT_W;
	localparam int PTR_W     = LIMIT_W + 1;
	localparam int SQ_W      = 2 * LIMIT_W;
	localparam int IN_W      = ((LIMIT_W + 7) / 8) * 8;
	localparam int OUT_W     = ((COUNT_W + 7) / 8) * 8;

	localparam logic [IDX_W-1:0]   MAP_LAST  = IDX_W'(MAP_DEPTH - 1);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [PTR_W-1:0]   FIRST_IDX = PTR_W'(2);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_DONE
	} sieve_state_t;

endpackage

### rtl/prime_count_sieve.sv
`timescale 1ns / 1ps
// Top level of the prime counting sieve: control FSM, composite bit map memory
// and result register. Depends on pcs_pkg.
//
// Usage: one input beat on the s_ group carries a limit N; one output beat on
// the m_ group later carries the number of primes <= N.
// The composite map lives in a 4096 x 1 synchronous memory (one read port, one
// write port, registered read). The scan reads index i each cycle and
// writes the entry back to zero once checked, so the map is left all zero at
// the end of every beat and needs no per-beat clearing pass. An unmarked i is
// counted; if i*i <= N the scan pauses and marks i*i, i*i+i, ... up to N, one
// write per cycle, then restarts the read stream at i+1.
// The memory's single write port paces the marking. One beat is processed at a
// time; N below 2 skips the scan and goes straight to the result.
// Reset: arst_n clears control state, then a sweep over all 4096 entries zeroes
// the map; s_tready stays low during the sweep.
// Stall: the result sits in an output register; the next limit is taken while
// it waits, and a finished count holds in the FSM until that register frees.
module prime_count_sieve
	import pcs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // [11:0] limit, rest zero
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // [9:0] prime_count, rest zero
);

	sieve_state_t state_q, state_d;

	// Composite map
	logic                map_mem [MAP_DEPTH];
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic                map_bit_s1;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic                wr_data;

	logic [IDX_W-1:0]    clr_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [PTR_W-1:0]    rd_q;
	logic                chk_valid_s1;
	logic [IDX_W-1:0]    chk_idx_s1;
	logic [COUNT_W-1:0]  count_q;
	logic [PTR_W-1:0]    mult_q;
	logic [IDX_W-1:0]    prime_q;
	logic                res_valid_q;
	logic [COUNT_W-1:0]  res_q;

	logic                in_beat;
	logic                out_free;
	logic                chk_prime;
	logic                chk_last;
	logic                sq_hit;
	logic                rd_go;
	logic [SQ_W-1:0]     sq;
	logic [PTR_W-1:0]    mult_next;
	logic [LIMIT_W-1:0]  in_limit;

	assign in_limit  = s_tdata[LIMIT_W-1:0];
	assign in_beat   = s_tvalid && s_tready;
	assign out_free  = !res_valid_q || m_tready;
	assign chk_prime = chk_valid_s1 && !map_bit_s1;
	assign chk_last  = chk_valid_s1 && (chk_idx_s1 == limit_q);
	assign sq        = SQ_W'(chk_idx_s1) * SQ_W'(chk_idx_s1);
	assign sq_hit    = chk_prime && (sq <= SQ_W'(limit_q));
	assign mult_next = mult_q + PTR_W'(prime_q);
	assign rd_go     = (state_q == ST_SCAN) && !sq_hit && !chk_last
		&& (rd_q <= PTR_W'(limit_q));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (clr_q == MAP_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					if (in_limit < LIMIT_W'(2)) state_d = ST_DONE;
					else                        state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				priority if (sq_hit) state_d = ST_MARK;
				else if (chk_last)   state_d = ST_DONE;
			end
			ST_MARK: begin
				if (mult_next > PTR_W'(limit_q)) state_d = ST_SCAN;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	// FSM outputs: handshake and memory ports
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = rd_q[IDX_W-1:0];
		wr_en    = 1'b0;
		wr_addr  = clr_q;
		wr_data  = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				wr_en = 1'b1;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_SCAN: begin
				rd_en = rd_go;
				// drop the checked entry back to zero for the next beat
				wr_en   = chk_valid_s1;
				wr_addr = chk_idx_s1;
			end
			ST_MARK: begin
				wr_en   = 1'b1;
				wr_addr = mult_q[IDX_W-1:0];
				wr_data = 1'b1;
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Map memory, no reset
	always_ff @(posedge clk) begin
		if (wr_en) map_mem[wr_addr] <= wr_data;
		if (rd_en) map_bit_s1 <= map_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			clr_q        <= '0;
			chk_valid_s1 <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT) clr_q <= clr_q + IDX_W'(1);
			if (in_beat) chk_valid_s1 <= 1'b0;
			else if (state_q == ST_SCAN) chk_valid_s1 <= rd_go;
			if (state_q == ST_DONE && out_free) res_valid_q <= 1'b1;
			else if (m_tready) res_valid_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			limit_q <= in_limit;
			count_q <= '0;
			rd_q    <= FIRST_IDX;
		end
		if (state_q == ST_SCAN) begin
			if (rd_go) begin
				chk_idx_s1 <= rd_q[IDX_W-1:0];
				rd_q       <= rd_q + PTR_W'(1);
			end
			if (chk_prime && count_q != COUNT_MAX) count_q <= count_q + COUNT_W'(1);
			if (sq_hit) begin
				// pause the read stream and restart it after the prime
				prime_q <= chk_idx_s1;
				mult_q  <= sq[PTR_W-1:0];
				rd_q    <= PTR_W'(chk_idx_s1) + PTR_W'(1);
			end
		end
		if (state_q == ST_MARK) mult_q <= mult_next;
		if (state_q == ST_DONE && out_free) res_q <= count_q;
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = OUT_W'(res_q);

endmodule

### tb/prime_count_sieve_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for prime_count_sieve: streams limits in, checks each prime count.
// Depends on pcs_pkg and the prime_count_sieve RTL; needs no other files.
module prime_count_sieve_tb
	import pcs_pkg::*;
;

	localparam int RANDOM_BEATS = 80;
	localparam int CALM_BEATS   = 15;         // last random beats run with no idling
	localparam int DRAIN_CYCLES = 12000;      // about one full-size sieve pass
	localparam int CYCLE_LIMIT  = 6_000_000;  // far above 100 beats at N = 4095
	localparam int REPORT_MAX   = 10;

	// Expected prime counts, oldest first, and the checks against them.
	class prime_count_board;
		logic [COUNT_W-1:0] pending_counts[$];
		int unsigned        limits_noted;
		int unsigned        counts_checked;
		int unsigned        mismatches;
		int unsigned        largest_limit;

		function int unsigned count_primes_upto(logic [LIMIT_W-1:0] top);
			bit          composite[MAP_DEPTH] = '{default: 1'b0};
			int unsigned found = 0;
			int unsigned n = 32'(top);
			int unsigned i;
			int unsigned m;
			if (n > MAX_LIMIT)
				n = MAX_LIMIT;
			composite[0] = 1'b1;
			composite[1] = 1'b1;
			if (n < 2)
				return 0;
			for (i = 2; i <= n; i++) begin
				if (composite[i])
					continue;
				found++;
				for (m = i + i; m <= n; m += i)
					composite[m] = 1'b1;
			end
			if (found > 32'(COUNT_MAX))
				found = 32'(COUNT_MAX);
			return found;
		endfunction

		function void note_limit(logic [LIMIT_W-1:0] top);
			pending_counts.push_back(COUNT_W'(count_primes_upto(top)));
			limits_noted++;
			if (32'(top) > largest_limit)
				largest_limit = 32'(top);
		endfunction

		function void check_count(logic [OUT_W-1:0] word);
			logic [COUNT_W-1:0] want;
			if (pending_counts.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("[%0t] unexpected result beat: prime_count=%0d", $time,
						word[COUNT_W-1:0]);
				return;
			end
			want = pending_counts.pop_front();
			counts_checked++;
			if (word !== OUT_W'(want)) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("[%0t] prime_count mismatch: expected %0d, got %0d (word %h)",
						$time, want, word[COUNT_W-1:0], word);
			end
		endfunction

		function int unsigned waiting();
			return pending_counts.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	prime_count_board board;
	bit               calm = 1'b0;
	int unsigned      cycle_count = 0;

	prime_count_sieve DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		// check the result first so a stray beat cannot consume a fresh expectation
		if (m_tvalid && m_tready)
			board.check_count(m_tdata);
		if (s_tvalid && s_tready)
			board.note_limit(s_tdata[LIMIT_W-1:0]);
	end

	// Result side: alternate stall bursts with ready stretches, hold ready once calm.
	initial begin
		int span;
		forever begin
			if (calm) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 2) == 0) begin
				span = $urandom_range(1, 14);
				m_tready <= 1'b0;
				repeat (span) @(posedge clk);
			end else begin
				span = $urandom_range(1, 60);
				m_tready <= 1'b1;
				repeat (span) @(posedge clk);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	// Present one limit, optionally after an idle burst, and hold it until accepted.
	task automatic send_limit(input logic [LIMIT_W-1:0] top);
		int gap;
		if (!calm && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 14);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'(top);
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Mostly small limits keep the run short; a tenth span the whole range.
	function automatic logic [LIMIT_W-1:0] pick_limit();
		int unsigned roll = $urandom_range(0, 99);
		if (roll < 70)
			return LIMIT_W'($urandom_range(0, 255));
		if (roll < 90)
			return LIMIT_W'($urandom_range(256, 1023));
		return LIMIT_W'($urandom_range(0, MAX_LIMIT));
	endfunction

	initial begin
		// below two, tiny primes, prime squares (marking starts at N), powers of two,
		// alternating bit patterns and the top of the range
		logic [LIMIT_W-1:0] directed_limits[20] = '{
			12'd0, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd9, 12'd11, 12'd25, 12'd49,
			12'd97, 12'd100, 12'd121, 12'd1024, 12'd2047, 12'd2048, 12'hAAA, 12'h555,
			12'd4094, 12'd4095
		};
		int k;
		board = new;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_limits[k])
			send_limit(directed_limits[k]);
		for (k = 0; k < RANDOM_BEATS; k++) begin
			if (k >= RANDOM_BEATS - CALM_BEATS)
				calm = 1'b1;
			send_limit(pick_limit());
		end
		s_tvalid <= 1'b0;

		while (board.waiting() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d limits (largest %0d) with random idling on both sides;",
			board.limits_noted, board.largest_limit);
		$display("%0d counts checked, %0d still pending, %0d mismatches over %0d cycles.",
			board.counts_checked, board.waiting(), board.mismatches, cycle_count);
		if (board.mismatches == 0 && board.waiting() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### prime_count_sieve.f
rtl/pcs_pkg.sv
rtl/prime_count_sieve.sv
tb/prime_count_sieve_tb.sv
